// ----- src/atc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atc_pkg
// Shared types, constants and the arctangent table of the tilt classifier.
// ----------------------------------------------------------------------------
package atc_pkg;

    localparam int ANGLE_ITERATIONS = 16;
    localparam int DIV_LAT          = 19;
    localparam int ANG_LAT          = 20 + ANGLE_ITERATIONS;
    localparam int PIPE_LAT         = DIV_LAT + ANG_LAT;
    localparam int ANGLE_MAX        = 23040;

    localparam logic [1:0] REG_ZERO_LEVEL   = 2'd0;
    localparam logic [1:0] REG_COUNTS_PER_G = 2'd1;
    localparam logic [1:0] REG_TILT_LIMIT   = 2'd2;

    localparam logic [1:0] CLASS_LEVEL = 2'd0;
    localparam logic [1:0] CLASS_ABOVE = 2'd1;
    localparam logic [1:0] CLASS_BELOW = 2'd2;

    typedef struct packed {
        logic [11:0] x_sample;
        logic [11:0] y_sample;
        logic [11:0] z_sample;
    } in_word_t;

    typedef struct packed {
        logic signed [15:0] x_accel;
        logic signed [15:0] y_accel;
        logic signed [15:0] z_accel;
        logic signed [15:0] tilt_angle;
        logic [1:0]         tilt_class;
    } out_word_t;

    // atan(2^-i) in degrees, Q.16
    function automatic logic [21:0] atan_deg(input logic [4:0] i);
        logic [21:0] v;
        case (i)
            5'd0:    v = 22'd2949120;
            5'd1:    v = 22'd1740967;
            5'd2:    v = 22'd919879;
            5'd3:    v = 22'd466945;
            5'd4:    v = 22'd234379;
            5'd5:    v = 22'd117304;
            5'd6:    v = 22'd58666;
            5'd7:    v = 22'd29335;
            5'd8:    v = 22'd14668;
            5'd9:    v = 22'd7334;
            5'd10:   v = 22'd3667;
            5'd11:   v = 22'd1833;
            5'd12:   v = 22'd917;
            5'd13:   v = 22'd458;
            5'd14:   v = 22'd229;
            5'd15:   v = 22'd115;
            5'd16:   v = 22'd57;
            5'd17:   v = 22'd29;
            5'd18:   v = 22'd14;
            5'd19:   v = 22'd7;
            5'd20:   v = 22'd4;
            5'd21:   v = 22'd2;
            5'd22:   v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- src/accelerometer_tilt_classifier.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accelerometer_tilt_classifier
// Three-axis samples to Q3.12 g, x tilt angle in Q7.8 degrees, tilt class.
// ----------------------------------------------------------------------------
// Usage:
//   sample channel: one word of x/y/z converter codes, taken on an edge with
//   sample_valid high and sample_stall low.
//   result channel: one word per sample word, in order, taken on an edge with
//   result_valid high and result_stall low.
//   cfg port: cfg_write with cfg_index selects zero level (0), counts per g
//   (1) or tilt limit (2); write only while no word is in flight.
// Pipeline: 19 divider stages, 2 square stages, 16 square root stages, one
//   CORDIC stage per iteration and two setup/output stages.
// Throughput: one word per cycle while result_stall does not freeze the pipeline; the single pipeline enable sets it.
// Reset: pipeline empties, registers return to 2048 / 410 / 15.0 degrees.
// Stall: when the last stage holds a word and result_stall is high, the whole
//   pipeline freezes and sample_stall rises in the same cycle.
// ----------------------------------------------------------------------------
module accelerometer_tilt_classifier (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                sample_valid,
    output logic                sample_stall,
    input  atc_pkg::in_word_t   sample_word,
    output logic                result_valid,
    input  logic                result_stall,
    output atc_pkg::out_word_t  result_word,
    input  logic                cfg_write,
    input  logic [1:0]          cfg_index,
    input  logic [14:0]         cfg_data
);

    localparam int LAT = atc_pkg::PIPE_LAT;

    logic [11:0]    zero_level_reg;
    logic [11:0]    counts_per_g_reg;
    logic [14:0]    tilt_limit_reg;
    logic [LAT-1:0] vld_reg;
    logic           en;

    logic signed [15:0] xa;
    logic signed [15:0] ya;
    logic signed [15:0] za;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_level_reg   <= 12'd2048;
            counts_per_g_reg <= 12'd410;
            tilt_limit_reg   <= 15'd3840;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                atc_pkg::REG_ZERO_LEVEL:   zero_level_reg   <= cfg_data[11:0];
                atc_pkg::REG_COUNTS_PER_G: counts_per_g_reg <= cfg_data[11:0];
                atc_pkg::REG_TILT_LIMIT:   tilt_limit_reg   <= cfg_data;
                default:                   ;
            endcase
        end
    end

    assign en = !(vld_reg[LAT-1] && result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], sample_valid};
    end

    atc_div u_div_x (
        .clk          (clk),
        .en           (en),
        .sample       (sample_word.x_sample),
        .zero_level   (zero_level_reg),
        .counts_per_g (counts_per_g_reg),
        .accel        (xa)
    );

    atc_div u_div_y (
        .clk          (clk),
        .en           (en),
        .sample       (sample_word.y_sample),
        .zero_level   (zero_level_reg),
        .counts_per_g (counts_per_g_reg),
        .accel        (ya)
    );

    atc_div u_div_z (
        .clk          (clk),
        .en           (en),
        .sample       (sample_word.z_sample),
        .zero_level   (zero_level_reg),
        .counts_per_g (counts_per_g_reg),
        .accel        (za)
    );

    atc_angle u_angle (
        .clk        (clk),
        .en         (en),
        .x_accel    (xa),
        .y_accel    (ya),
        .z_accel    (za),
        .tilt_limit (tilt_limit_reg),
        .result     (result_word)
    );

    assign sample_stall = !en;
    assign result_valid = vld_reg[LAT-1];

`ifndef SYNTHESIS
    a_stall_tracks_output: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall == (result_valid && result_stall))
        else $error("sample_stall does not follow output backpressure");

    a_class_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result_word.tilt_class != 2'd3)
        else $error("tilt class out of range");

    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result_word.tilt_angle <= 16'sd23040 &&
                          result_word.tilt_angle >= -16'sd23040))
        else $error("tilt angle out of range");

    a_class_above: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_word.tilt_class == atc_pkg::CLASS_ABOVE) |->
        (17'(result_word.tilt_angle) > $signed({2'b0, tilt_limit_reg})))
        else $error("class above without angle over limit");
`endif

endmodule

// ----- src/atc_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atc_div
// One axis: (sample - zero) * 4096 / counts_per_g, rounded and saturated to
// Q3.12. Restoring divider: setup, one quotient bit per divide stage, saturation; 19 stages.
// ----------------------------------------------------------------------------
module atc_div (
    input  logic               clk,
    input  logic               en,
    input  logic [11:0]        sample,
    input  logic [11:0]        zero_level,
    input  logic [11:0]        counts_per_g,
    output logic signed [15:0] accel
);

    logic signed [12:0] diff;
    logic [11:0]        mag;
    logic [11:0]        dsr;
    logic [24:0]        num;

    logic [11:0] rem_reg  [0:17];
    logic [16:0] quo_reg  [0:17];
    logic [16:0] nlow_reg [0:17];
    logic [11:0] dsr_reg  [0:17];
    logic        neg_reg  [0:17];
    logic        ovf_reg  [0:17];
    logic signed [15:0] accel_reg;

    always_comb
    begin
        diff = $signed({1'b0, sample}) - $signed({1'b0, zero_level});
        mag  = diff[12] ? 12'(-diff) : 12'(diff);
        dsr  = (counts_per_g == 12'd0) ? 12'd1 : counts_per_g;
        num  = {1'b0, mag, 12'b0} + {14'b0, dsr[11:1]};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= {4'b0, num[24:17]};
            quo_reg[0]  <= '0;
            nlow_reg[0] <= num[16:0];
            dsr_reg[0]  <= dsr;
            neg_reg[0]  <= diff[12];
            ovf_reg[0]  <= {4'b0, num[24:17]} >= dsr;
        end
    end

    for (genvar s = 1; s <= 17; s++)
    begin : g_stage
        logic [12:0] trial;
        logic        ge;

        always_comb
        begin
            trial = {rem_reg[s-1], nlow_reg[s-1][17-s]};
            ge    = trial >= {1'b0, dsr_reg[s-1]};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s]  <= ge ? 12'(trial - {1'b0, dsr_reg[s-1]}) : trial[11:0];
                quo_reg[s]  <= {quo_reg[s-1][15:0], ge};
                nlow_reg[s] <= nlow_reg[s-1];
                dsr_reg[s]  <= dsr_reg[s-1];
                neg_reg[s]  <= neg_reg[s-1];
                ovf_reg[s]  <= ovf_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (neg_reg[17])
            begin
                if (ovf_reg[17] || quo_reg[17] > 17'd32768)
                    accel_reg <= -16'sd32768;
                else
                    accel_reg <= 16'(-$signed({1'b0, quo_reg[17]}));
            end
            else
            begin
                if (ovf_reg[17] || quo_reg[17] > 17'd32767)
                    accel_reg <= 16'sd32767;
                else
                    accel_reg <= $signed(quo_reg[17][15:0]);
            end
        end
    end

    assign accel = accel_reg;

endmodule

// ----- src/atc_angle.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atc_angle
// Tilt angle atan(x / sqrt(y^2 + z^2)) in Q7.8 degrees and its class.
// Squares, pipelined integer square root, pipelined vectoring CORDIC.
// ----------------------------------------------------------------------------
module atc_angle (
    input  logic               clk,
    input  logic               en,
    input  logic signed [15:0] x_accel,
    input  logic signed [15:0] y_accel,
    input  logic signed [15:0] z_accel,
    input  logic [14:0]        tilt_limit,
    output atc_pkg::out_word_t result
);

    localparam int ITER = atc_pkg::ANGLE_ITERATIONS;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } axes_t;

    axes_t       axes_m_reg;
    logic [31:0] py_reg;
    logic [31:0] pz_reg;

    axes_t       axes_s_reg [0:16];
    logic [31:0] sq_v_reg   [0:16];
    logic [31:0] sq_r_reg   [0:16];

    axes_t              axes_c_reg [0:ITER];
    logic signed [27:0] cx_reg     [0:ITER];
    logic signed [27:0] cy_reg     [0:ITER];
    logic signed [25:0] acc_reg    [0:ITER];
    logic               rz_reg     [0:ITER];

    atc_pkg::out_word_t result_reg;

    logic signed [25:0] rounded;
    logic signed [15:0] ang;
    logic signed [16:0] lim;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            axes_m_reg <= '{x: x_accel, y: y_accel, z: z_accel};
            py_reg     <= 32'(y_accel * y_accel);
            pz_reg     <= 32'(z_accel * z_accel);
            axes_s_reg[0] <= axes_m_reg;
            sq_v_reg[0]   <= py_reg + pz_reg;
            sq_r_reg[0]   <= '0;
        end
    end

    for (genvar k = 1; k <= 16; k++)
    begin : g_sqrt
        logic [31:0] bitv;
        logic [32:0] trial;

        always_comb
        begin
            bitv  = 32'(1) << (2 * (16 - k));
            trial = {1'b0, sq_r_reg[k-1]} + {1'b0, bitv};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                axes_s_reg[k] <= axes_s_reg[k-1];
                if ({1'b0, sq_v_reg[k-1]} >= trial)
                begin
                    sq_v_reg[k] <= sq_v_reg[k-1] - trial[31:0];
                    sq_r_reg[k] <= (sq_r_reg[k-1] >> 1) + bitv;
                end
                else
                begin
                    sq_v_reg[k] <= sq_v_reg[k-1];
                    sq_r_reg[k] <= sq_r_reg[k-1] >> 1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            axes_c_reg[0] <= axes_s_reg[16];
            cx_reg[0]     <= $signed({4'b0, sq_r_reg[16][15:0], 8'b0});
            cy_reg[0]     <= $signed({{4{axes_s_reg[16].x[15]}}, axes_s_reg[16].x, 8'b0});
            acc_reg[0]    <= '0;
            rz_reg[0]     <= sq_r_reg[16][15:0] == 16'd0;
        end
    end

    for (genvar i = 1; i <= ITER; i++)
    begin : g_cordic
        logic signed [27:0] dx;
        logic signed [27:0] dy;
        logic signed [25:0] da;

        always_comb
        begin
            dx = cy_reg[i-1] >>> (i - 1);
            dy = cx_reg[i-1] >>> (i - 1);
            da = $signed({4'b0, atc_pkg::atan_deg(5'(i - 1))});
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                axes_c_reg[i] <= axes_c_reg[i-1];
                rz_reg[i]     <= rz_reg[i-1];
                if (!cy_reg[i-1][27])
                begin
                    cx_reg[i]  <= cx_reg[i-1] + dx;
                    cy_reg[i]  <= cy_reg[i-1] - dy;
                    acc_reg[i] <= acc_reg[i-1] + da;
                end
                else
                begin
                    cx_reg[i]  <= cx_reg[i-1] - dx;
                    cy_reg[i]  <= cy_reg[i-1] + dy;
                    acc_reg[i] <= acc_reg[i-1] - da;
                end
            end
        end
    end

    always_comb
    begin
        rounded = (acc_reg[ITER] + 26'sd128) >>> 8;
        if (rz_reg[ITER])
        begin
            if (axes_c_reg[ITER].x > 16'sd0)
                ang = 16'(atc_pkg::ANGLE_MAX);
            else if (axes_c_reg[ITER].x < 16'sd0)
                ang = -16'(atc_pkg::ANGLE_MAX);
            else
                ang = '0;
        end
        else if (rounded > 26'(atc_pkg::ANGLE_MAX))
            ang = 16'(atc_pkg::ANGLE_MAX);
        else if (rounded < -26'(atc_pkg::ANGLE_MAX))
            ang = -16'(atc_pkg::ANGLE_MAX);
        else
            ang = rounded[15:0];
        lim = $signed({2'b0, tilt_limit});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            result_reg.x_accel    <= axes_c_reg[ITER].x;
            result_reg.y_accel    <= axes_c_reg[ITER].y;
            result_reg.z_accel    <= axes_c_reg[ITER].z;
            result_reg.tilt_angle <= ang;
            if (17'(ang) > lim)
                result_reg.tilt_class <= atc_pkg::CLASS_ABOVE;
            else if (17'(ang) < -lim)
                result_reg.tilt_class <= atc_pkg::CLASS_BELOW;
            else
                result_reg.tilt_class <= atc_pkg::CLASS_LEVEL;
        end
    end

    assign result = result_reg;

endmodule
